// File: rtl/tswd_pkg.sv
// ----------------------------------------------------------------------------
// tswd_pkg
// Shared types and constants of the spill word deframer.
// ----------------------------------------------------------------------------
package tswd_pkg;

  // Event layout inside the events field
  localparam int unsigned EVENT_WORDS = 10;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned ERR_W   = 2;

  localparam logic [FIELD_W-1:0] FIRST_FIELD  = 5'd1;
  localparam logic [FIELD_W-1:0] EVENTS_FIELD = 5'd14;
  localparam logic [FIELD_W-1:0] SKIP_FROM    = 5'd17;
  localparam logic [FIELD_W-1:0] SKIP_TO      = 5'd20;
  localparam logic [FIELD_W-1:0] LAST_FIELD   = 5'd27;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_HEADER   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO_LEN = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] field_number;
    logic [WORD_W-1:0]  payload_index;
    logic [WORD_W-1:0]  payload_word;
    logic               in_event_field;
    logic [POS_W-1:0]   event_word_pos;
    logic               last_in_field;
    logic [ERR_W-1:0]   error_code;
  } result_t;

endpackage

// File: rtl/tracker_spill_word_deframer_core.sv
// ----------------------------------------------------------------------------
// tracker_spill_word_deframer_core
// Splits a spill packet word stream into tagged payload beats.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the 32-bit packet words, one beat per word. Each field is
//   a length word, a header word with the field number, then payload words.
//   m_axis carries one beat per payload word, tagged with field number,
//   index in field, event position (events field only) and tlast at the end
//   of each field. Length and header words produce no beat.
//   A zero length or a wrong header yields one error beat (tuser error code
//   nonzero) and the block then drops every word until reset.
// Path: a word passes the input register, then the parser with its result
//   register, before it leaves on m_axis.
// Throughput: one word per cycle while m_axis is not stalled; the parser state update is a single pass.
// Reset: rst_ni clears the parser to expect a length word for field 1.
// Stall: with m_axis_tready_i low and a beat held, the parser takes no word;
//   the input register takes at most one more, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module tracker_spill_word_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // data_word[31:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // field_number[4:0], payload_index[36:5], payload_word[68:37],
  // event_word_pos[72:69], zero fill[79:73]
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,  // last_in_field
  output logic [2:0]  m_axis_tuser_o   // in_event_field[0], error_code[2:1]
);

  logic                        w_valid;
  logic                        w_ready;
  logic [tswd_pkg::WORD_W-1:0] w_data;
  tswd_pkg::result_t           res;

  tswd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (w_valid),
    .ready_i (w_ready),
    .data_o  (w_data)
  );

  tswd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (w_valid),
    .ready_o  (w_ready),
    .data_i   (w_data),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (res)
  );

  assign m_axis_tdata_o = {7'd0, res.event_word_pos, res.payload_word,
                           res.payload_index, res.field_number};
  assign m_axis_tlast_o = res.last_in_field;
  assign m_axis_tuser_o = {res.error_code, res.in_event_field};

endmodule

// File: rtl/tswd_in_reg.sv
// ----------------------------------------------------------------------------
// tswd_in_reg
// Input register stage: captures one stream word per cycle while the parser accepts.
// ----------------------------------------------------------------------------
module tswd_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [tswd_pkg::WORD_W-1:0] data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [tswd_pkg::WORD_W-1:0] data_o
);

  logic                        vld_q, vld_d;
  logic [tswd_pkg::WORD_W-1:0] data_q;
  logic                        load;

  assign ready_o = !vld_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule

// File: rtl/tswd_parser.sv
// ----------------------------------------------------------------------------
// tswd_parser
// Field parser state and result register; one word handled per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tswd_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [tswd_pkg::WORD_W-1:0] data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output tswd_pkg::result_t           result_o
);

  localparam logic [1:0] PH_LENGTH  = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_HALTED  = 2'd3;

  logic [1:0]                   phase_q, phase_d;
  logic [tswd_pkg::FIELD_W-1:0] exp_q, exp_d;
  logic [tswd_pkg::WORD_W-1:0]  left_q, left_d;
  logic [tswd_pkg::WORD_W-1:0]  count_q, count_d;
  logic [tswd_pkg::POS_W-1:0]   epos_q, epos_d;
  logic [tswd_pkg::POS_W:0]     epos_inc;
  logic [tswd_pkg::FIELD_W-1:0] exp_next;

  logic                         out_vld_q, out_vld_d;
  tswd_pkg::result_t            res_q, res_d;
  logic                         take;
  logic                         emit;
  logic                         in_ev;
  logic                         last;

  assign ready_o = !out_vld_q || ready_i;
  assign take    = valid_i && ready_o;

  // field numbering skips 18 and 19, wraps after the last field
  always_comb begin
    if (exp_q == tswd_pkg::SKIP_FROM) begin
      exp_next = tswd_pkg::SKIP_TO;
    end else if (exp_q >= tswd_pkg::LAST_FIELD) begin
      exp_next = tswd_pkg::FIRST_FIELD;
    end else begin
      exp_next = exp_q + 5'd1;
    end
  end

  assign in_ev    = (exp_q == tswd_pkg::EVENTS_FIELD);
  assign last     = (left_q <= 32'd1);
  assign epos_inc = {1'b0, epos_q} + 5'd1;

  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    left_d  = left_q;
    count_d = count_q;
    epos_d  = epos_q;
    emit    = 1'b0;
    res_d   = '0;
    res_d.field_number = exp_q;
    res_d.payload_word = data_i;
    if (take) begin
      case (phase_q)
        PH_LENGTH: begin
          if (data_i == '0) begin
            emit             = 1'b1;
            res_d.error_code = tswd_pkg::ERR_ZERO_LEN;
            phase_d          = PH_HALTED;
          end else begin
            left_d  = data_i - 32'd1;
            count_d = '0;
            epos_d  = '0;
            phase_d = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (data_i != {27'd0, exp_q}) begin
            emit             = 1'b1;
            res_d.error_code = tswd_pkg::ERR_HEADER;
            phase_d          = PH_HALTED;
          end else if (left_q == '0) begin
            exp_d   = exp_next;
            phase_d = PH_LENGTH;
            count_d = '0;
            epos_d  = '0;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          emit                 = 1'b1;
          res_d.payload_index  = count_q;
          res_d.in_event_field = in_ev;
          res_d.event_word_pos = in_ev ? epos_q : '0;
          res_d.last_in_field  = last;
          res_d.error_code     = tswd_pkg::ERR_NONE;
          if (last) begin
            exp_d   = exp_next;
            phase_d = PH_LENGTH;
            left_d  = '0;
            count_d = '0;
            epos_d  = '0;
          end else begin
            left_d  = left_q - 32'd1;
            count_d = count_q + 32'd1;
            if (in_ev) begin
              epos_d = (epos_inc >= 5'(tswd_pkg::EVENT_WORDS)) ? '0 : epos_inc[3:0];
            end
          end
        end
        default: begin
          // halted: words are dropped until reset
          phase_d = PH_HALTED;
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (take && emit) begin
      out_vld_d = 1'b1;
    end else if (ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LENGTH;
      exp_q     <= tswd_pkg::FIRST_FIELD;
      left_q    <= '0;
      count_q   <= '0;
      epos_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      exp_q     <= exp_d;
      left_q    <= left_d;
      count_q   <= count_d;
      epos_q    <= epos_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = out_vld_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && emit && res_d.error_code != tswd_pkg::ERR_NONE) |=> (phase_q == PH_HALTED))
    else $error("error result without halt");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALTED) |=> (phase_q == PH_HALTED))
    else $error("left halted state without reset");

  a_no_emit_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALTED && !out_vld_q) |=> !out_vld_q)
    else $error("result produced while halted");

  a_field_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != 5'd0 && exp_q != 5'd18 && exp_q != 5'd19 && exp_q <= tswd_pkg::LAST_FIELD))
    else $error("illegal expected field number");

  a_epos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (epos_q < 4'(tswd_pkg::EVENT_WORDS)))
    else $error("event position out of range");
`endif

endmodule

// File: tb/sv/tswd_beat_monitor.sv
// ----------------------------------------------------------------------------
// tswd_beat_monitor
// Watches both stream ports of the spill word deframer, runs its own parser
// on every input beat and checks each output beat against the oldest beat
// that parser still owes.
// ----------------------------------------------------------------------------
module tswd_beat_monitor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [31:0]       s_axis_tdata_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [79:0]       m_axis_tdata_i,
  input  logic              m_axis_tlast_i,
  input  logic [2:0]        m_axis_tuser_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       owed_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    WANT_LENGTH,
    WANT_HEADER,
    IN_PAYLOAD,
    STOPPED
  } parse_state_e;

  parse_state_e                 state_q;
  logic [tswd_pkg::FIELD_W-1:0] field_q;
  logic [tswd_pkg::WORD_W-1:0]  remaining_q;
  logic [tswd_pkg::WORD_W-1:0]  index_q;
  logic [tswd_pkg::POS_W-1:0]   evpos_q;

  tswd_pkg::result_t owed_beats[$];
  tswd_pkg::result_t new_beat;
  int unsigned       mismatch_total = 0;
  int unsigned       owed_total     = 0;

  assign mismatch_count_o = mismatch_total;
  assign owed_count_o     = owed_total;

  function automatic void advance_field();
    if (field_q == tswd_pkg::SKIP_FROM) begin
      field_q = tswd_pkg::SKIP_TO;
    end else if (field_q >= tswd_pkg::LAST_FIELD) begin
      field_q = tswd_pkg::FIRST_FIELD;
    end else begin
      field_q = field_q + 1'b1;
    end
    state_q     = WANT_LENGTH;
    remaining_q = '0;
    index_q     = '0;
    evpos_q     = '0;
  endfunction

  // Returns 1 when the word produces an output beat.
  function automatic bit deframe_word(input logic [tswd_pkg::WORD_W-1:0] w,
                                      output tswd_pkg::result_t r);
    r              = '0;
    r.field_number = field_q;
    r.payload_word = w;
    case (state_q)
      WANT_LENGTH: begin
        if (w == '0) begin
          r.error_code = tswd_pkg::ERR_ZERO_LEN;
          state_q      = STOPPED;
          return 1'b1;
        end
        remaining_q = w - 1;
        index_q     = '0;
        evpos_q     = '0;
        state_q     = WANT_HEADER;
        return 1'b0;
      end
      WANT_HEADER: begin
        // full word compare, upper bits must be zero too
        if (w != tswd_pkg::WORD_W'(field_q)) begin
          r.error_code = tswd_pkg::ERR_HEADER;
          state_q      = STOPPED;
          return 1'b1;
        end
        if (remaining_q == '0) begin
          advance_field();
        end else begin
          state_q = IN_PAYLOAD;
        end
        return 1'b0;
      end
      IN_PAYLOAD: begin
        r.error_code     = tswd_pkg::ERR_NONE;
        r.payload_index  = index_q;
        r.in_event_field = (field_q == tswd_pkg::EVENTS_FIELD);
        r.event_word_pos = r.in_event_field ? evpos_q : '0;
        r.last_in_field  = (remaining_q <= 1);
        if (r.last_in_field) begin
          advance_field();
        end else begin
          remaining_q = remaining_q - 1;
          index_q     = index_q + 1;
          if (r.in_event_field) begin
            if (evpos_q == tswd_pkg::POS_W'(tswd_pkg::EVENT_WORDS - 1)) begin
              evpos_q = '0;
            end else begin
              evpos_q = evpos_q + 1'b1;
            end
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_total++;
    end
  endtask

  task automatic compare_beat(input tswd_pkg::result_t want);
    check_field("field_number", 32'(want.field_number), 32'(m_axis_tdata_i[4:0]));
    check_field("payload_index", want.payload_index, m_axis_tdata_i[36:5]);
    check_field("payload_word", want.payload_word, m_axis_tdata_i[68:37]);
    check_field("event_word_pos", 32'(want.event_word_pos), 32'(m_axis_tdata_i[72:69]));
    check_field("tdata zero fill", 32'd0, 32'(m_axis_tdata_i[79:73]));
    check_field("last_in_field", 32'(want.last_in_field), 32'(m_axis_tlast_i));
    check_field("in_event_field", 32'(want.in_event_field), 32'(m_axis_tuser_i[0]));
    check_field("error_code", 32'(want.error_code), 32'(m_axis_tuser_i[2:1]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     = WANT_LENGTH;
      field_q     = tswd_pkg::FIRST_FIELD;
      remaining_q = '0;
      index_q     = '0;
      evpos_q     = '0;
      owed_beats.delete();
      owed_total  = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (deframe_word(s_axis_tdata_i, new_beat)) begin
          owed_beats = {owed_beats, new_beat};
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (owed_beats.size() == 0) begin
          $error("unexpected beat: tdata 0x%0h tlast %0b tuser 0x%0h",
                 m_axis_tdata_i, m_axis_tlast_i, m_axis_tuser_i);
          mismatch_total++;
        end else begin
          compare_beat(owed_beats.pop_front());
        end
      end
      owed_total = owed_beats.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives spill packets into the word deframer: a few hand-built fields with
// edge-case payloads, then random packets with bursty input and a stalling
// output, ending in one error or an endless field. The monitor checks beats.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 1200;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data  = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [79:0] m_data;
  logic        m_last;
  logic [2:0]  m_user;

  int unsigned mismatches;
  int unsigned owed;

  logic [4:0]  field_no    = tswd_pkg::FIRST_FIELD;
  int unsigned burst_left  = 0;
  int unsigned words_sent  = 0;

  tracker_spill_word_deframer_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  tswd_beat_monitor beat_monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .m_axis_tlast_i   (m_last),
    .m_axis_tuser_i   (m_user),
    .mismatch_count_o (mismatches),
    .owed_count_o     (owed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("testbench: FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= w;
    do @(posedge clk); while (!s_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    s_valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
    burst_left = 0;
  endtask

  // Length and header of the next field; field_no moves on to the one after.
  task automatic open_field(input int unsigned n_payload);
    send_word(n_payload + 1);
    send_word(32'(field_no));
    if (field_no == tswd_pkg::SKIP_FROM) begin
      field_no = tswd_pkg::SKIP_TO;
    end else if (field_no == tswd_pkg::LAST_FIELD) begin
      field_no = tswd_pkg::FIRST_FIELD;
    end else begin
      field_no = field_no + 1'b1;
    end
  endtask

  function automatic logic [31:0] pick_payload();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_field();
    int unsigned n;
    if (field_no == tswd_pkg::EVENTS_FIELD) begin
      // whole events plus a short tail
      n = $urandom_range(0, 3) * tswd_pkg::EVENT_WORDS
          + $urandom_range(0, tswd_pkg::EVENT_WORDS - 1);
    end else begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        9:       n = $urandom_range(5, 20);
        default: n = $urandom_range(1, 4);
      endcase
    end
    open_field(n);
    repeat (n) send_word(pick_payload());
  endtask

  // Output side: changing stall modes plus one long hold-off.
  initial begin
    int unsigned cyc;
    int unsigned mode;
    int unsigned mode_left;
    cyc       = 0;
    mode      = 0;
    mode_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 300) begin
        m_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0:       m_ready <= 1'b1;
          1:       m_ready <= ($urandom_range(0, 1) == 1);
          default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    bit          drained_once;
    logic [31:0] bad;
    drained_once = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty field, payload extremes, alternating bit patterns, single-word field
    open_field(0);
    open_field(2);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    open_field(2);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    open_field(1);
    send_word($urandom);

    while (words_sent < RANDOM_WORDS) begin
      send_random_field();
      if (!drained_once && words_sent > RANDOM_WORDS / 2) begin
        drained_once = 1'b1;
        hold_until_drained();
      end
    end

    // the block only leaves an error through reset, so one ending per run
    case ($urandom_range(0, 2))
      0: begin
        send_word(32'h0000_0000);
        repeat (20) send_word($urandom);
      end
      1: begin
        send_word($urandom_range(1, 8));
        if ($urandom_range(0, 1) == 1) begin
          bad = {27'($urandom_range(1, 32'h07FF_FFFF)), field_no};
        end else begin
          do bad = $urandom; while (bad == 32'(field_no));
        end
        send_word(bad);
        repeat (20) send_word($urandom);
      end
      default: begin
        // longest possible field, never finished
        send_word(32'hFFFF_FFFF);
        send_word(32'(field_no));
        repeat (30) send_word(pick_payload());
      end
    endcase

    s_valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tswd_pkg.sv
rtl/tswd_in_reg.sv
rtl/tswd_parser.sv
rtl/tracker_spill_word_deframer_core.sv
tb/sv/tswd_beat_monitor.sv
tb/sv/testbench.sv
